// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the block average core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/rgba_pkg.sv =====
// Package with widths, register indexes and divider handshake types.
package rgba_pkg;

   localparam int MAX_WINDOW  = 256;
   localparam int SAMPLE_BITS = 16;

   localparam int RANGE_W    = 16;
   localparam int WLEN_W     = 9;
   localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
   localparam int DIVIDEND_W = SUM_W - 1;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_RANGE_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LEN  = CSR_IDX_W'(1);

   localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(1000);
   localparam logic [WLEN_W-1:0]  WLEN_RESET  = WLEN_W'(8);

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [LEN_W-1:0]      divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/core/rgba_channels.sv =====
// Channel interfaces: sample input, average result and register write port.
interface rgba_req_if;
   import rgba_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface rgba_rsp_if;
   import rgba_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          avg_ready;
   logic signed [SAMPLE_BITS-1:0] average;
   modport source (output valid, output avg_ready, output average, input ready);
   modport sink (input valid, input avg_ready, input average, output ready);
endinterface

interface rgba_csr_if;
   import rgba_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rgba_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
module rgba_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rgba_pkg::div_cmd_type cmd,
   output rgba_pkg::div_stat_type stat,
   output logic [rgba_pkg::DIVIDEND_W-1:0] quotient
);
   import rgba_pkg::*;

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic [LEN_W-1:0]      dvs_ff, dvs_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [LEN_W:0]        shifted;
   logic [LEN_W:0]        trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the trial remainder only when it did not borrow
         if (!trial[LEN_W]) begin
            rem_in = trial[LEN_W-1:0];
         end else begin
            rem_in = shifted[LEN_W-1:0];
         end
         quo_in  = {quo_ff[DIVIDEND_W-2:0], ~trial[LEN_W]};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ===== rtl/core/range_gated_block_average.sv =====
// Top level of the range-gated block averager.
//
// Takes one signed sample word at a time and returns exactly one result word
// for each. The first sample after reset opens a window and becomes its
// reference; a sample farther than range_limit from the reference reopens the
// window around itself; any other sample joins the window. When the window
// holds window_len samples (values below 2 act as 2, above 256 as 256) the
// result carries avg_ready = 1 and the window sum divided by the length,
// truncated toward zero and saturated to 16 bits; the window then restarts
// holding only the reference. Other results carry avg_ready = 0, average = 0.
// A sample that does not close a window passes from the check state to the
// put state, which loads the result register; the input takes the next sample
// once the block is back in idle. A sample that closes a window goes from the
// check state through the divide state, where the restoring divider produces
// one quotient bit per cycle over the 24-bit magnitude of the window sum, to
// the put state. The put state waits while the output register stays full. The
// input is not ready while a sample is in work, but the next sample is taken
// while the previous result still waits in the output register. Register
// writes are always accepted and take effect from the next sample.
`include "assert_macros.svh"

module range_gated_block_average (
   input logic       clock,
   input logic       reset,
   rgba_req_if.sink  req_port,
   rgba_rsp_if.source rsp_port,
   rgba_csr_if.sink  csr_port
);
   import rgba_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_PUT
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [RANGE_W-1:0] range_ff, range_in;
   logic [WLEN_W-1:0]  wlen_ff, wlen_in;

   // window state
   logic [SAMPLE_BITS-1:0] ref_ff, ref_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   // work registers
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic                   neg_ff, neg_in;
   logic                   res_rdy_ff, res_rdy_in;
   logic [SAMPLE_BITS-1:0] res_avg_ff, res_avg_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic                   out_rdy_ff, out_rdy_in;
   logic [SAMPLE_BITS-1:0] out_avg_ff, out_avg_in;

   div_cmd_type            div_cmd;
   div_stat_type           div_stat;
   logic [DIVIDEND_W-1:0]  div_quo;

   logic [LEN_W-1:0]       eff_len;
   logic [SAMPLE_BITS:0]   dev;
   logic [SAMPLE_BITS:0]   dev_mag;
   logic [SUM_W-1:0]       smp_ext;
   logic [SUM_W-1:0]       ref_ext;
   logic [SUM_W-1:0]       sum_join;
   logic [SUM_W-1:0]       sum_mag;
   logic [CNT_W-1:0]       cnt_join;
   logic                   req_fire;

   rgba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign req_port.ready   = (state_ff == S_IDLE);
   assign csr_port.ready   = 1'b1;
   assign rsp_port.valid   = out_valid_ff;
   assign rsp_port.avg_ready = out_rdy_ff;
   assign rsp_port.average = out_avg_ff;
   assign req_fire         = req_port.valid && req_port.ready;

   // clamp the programmed length into the supported range
   always_comb begin
      if (int'(wlen_ff) < 2) begin
         eff_len = LEN_W'(2);
      end else if (int'(wlen_ff) > MAX_WINDOW) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end else begin
         eff_len = LEN_W'(wlen_ff);
      end
   end

   // deviation from reference, sign-extended by one bit
   assign dev     = {ref_ff[SAMPLE_BITS-1], ref_ff} - {smp_ff[SAMPLE_BITS-1], smp_ff};
   assign dev_mag = dev[SAMPLE_BITS] ? (~dev + (SAMPLE_BITS+1)'(1)) : dev;

   assign smp_ext  = {{(SUM_W-SAMPLE_BITS){smp_ff[SAMPLE_BITS-1]}}, smp_ff};
   assign ref_ext  = {{(SUM_W-SAMPLE_BITS){ref_ff[SAMPLE_BITS-1]}}, ref_ff};
   assign sum_join = sum_ff + smp_ext;
   assign sum_mag  = sum_join[SUM_W-1] ? (~sum_join + SUM_W'(1)) : sum_join;
   assign cnt_join = cnt_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      range_in     = range_ff;
      wlen_in      = wlen_ff;
      ref_in       = ref_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      smp_in       = smp_ff;
      neg_in       = neg_ff;
      res_rdy_in   = res_rdy_ff;
      res_avg_in   = res_avg_ff;
      out_valid_in = out_valid_ff;
      out_rdy_in   = out_rdy_ff;
      out_avg_in   = out_avg_ff;
      div_cmd      = '0;

      // register writes
      if (csr_port.valid) begin
         unique case (csr_port.index)
            REG_RANGE_LIMIT: range_in = csr_port.data[RANGE_W-1:0];
            REG_WINDOW_LEN:  wlen_in  = csr_port.data[WLEN_W-1:0];
            default: ;
         endcase
      end

      // drop the result word once the sink takes it
      if (out_valid_ff && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               smp_in   = req_port.sample;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_rdy_in = 1'b0;
            res_avg_in = '0;
            state_in   = S_PUT;
            if (cnt_ff == '0 || dev_mag > {1'b0, range_ff}) begin
               // open a new window around this sample
               ref_in = smp_ff;
               sum_in = smp_ext;
               cnt_in = CNT_W'(1);
            end else if (cnt_join >= CNT_W'(eff_len)) begin
               // close the window: divide the full sum, restart from reference
               div_cmd.start    = 1'b1;
               div_cmd.dividend = sum_mag[DIVIDEND_W-1:0];
               div_cmd.divisor  = eff_len;
               neg_in           = sum_join[SUM_W-1];
               sum_in           = ref_ext;
               cnt_in           = CNT_W'(1);
               state_in         = S_DIV;
            end else begin
               sum_in = sum_join;
               cnt_in = cnt_join;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               res_rdy_in = 1'b1;
               // saturate the signed mean to the sample range
               if (neg_ff) begin
                  if (div_quo > DIVIDEND_W'(2 ** (SAMPLE_BITS - 1))) begin
                     res_avg_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                  end else begin
                     res_avg_in = ~div_quo[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
                  end
               end else begin
                  if (div_quo > DIVIDEND_W'(2 ** (SAMPLE_BITS - 1) - 1)) begin
                     res_avg_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                  end else begin
                     res_avg_in = div_quo[SAMPLE_BITS-1:0];
                  end
               end
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_port.ready) begin
               out_valid_in = 1'b1;
               out_rdy_in   = res_rdy_ff;
               out_avg_in   = res_avg_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         range_ff     <= RANGE_RESET;
         wlen_ff      <= WLEN_RESET;
         ref_ff       <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         range_ff     <= range_in;
         wlen_ff      <= wlen_in;
         ref_ff       <= ref_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
      smp_ff     <= smp_in;
      neg_ff     <= neg_in;
      res_rdy_ff <= res_rdy_in;
      res_avg_ff <= res_avg_in;
      out_rdy_ff <= out_rdy_in;
      out_avg_ff <= out_avg_in;
   end

   `ASSERT_IMPLIES(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_WINDOW))
   `ASSERT_IMPLIES(a_div_start_free, clock, reset, div_cmd.start, !div_stat.busy)
   `ASSERT_IMPLIES(a_div_done_state, clock, reset, div_stat.done, state_ff == S_DIV)
   `ASSERT_NEXT(a_accept_check, clock, reset, req_fire, state_ff == S_CHECK)
   `ASSERT_IMPLIES(a_idle_zero, clock, reset, out_valid_ff && !out_rdy_ff, out_avg_ff == '0)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the range-gated block averager: directed script, then random phases.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rgba_pkg::*;

   // Give up well past the slowest legal run (about 500 words, each with full gaps and stalls).
   localparam int CYCLE_LIMIT = 200000;
   // Allow a window-closing word (divider pass) to drain before the final verdict.
   localparam int TAIL_CYCLES = 40;
   // Random part: one long window phase, the rest short bursts, mostly with small windows.
   localparam int RAND_PHASES = 10;
   localparam int LONG_PHASE  = 4;
   // Leave the final phases free of gaps and stalls.
   localparam int CALM_PHASES = 2;
   localparam int MAX_REPORTS = 10;

   localparam longint AVG_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint AVG_MIN = -AVG_MAX - 1;

   // Index that maps to no register; writes to it must leave the block unchanged.
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = CSR_IDX_W'(9);

   // One result word as the block returns it.
   typedef struct packed {
      logic                          avg_ready;
      logic signed [SAMPLE_BITS-1:0] average;
   } avg_word_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   // One line of the directed script: a sample word or a register write. Rows
   // with a hand-typed result carry it in want; the others use the predictor.
   typedef struct packed {
      row_kind_type                  kind;
      logic [CSR_IDX_W-1:0]          index;
      logic [CSR_DATA_W-1:0]         data;
      logic signed [SAMPLE_BITS-1:0] code;
      logic                          typed;
      avg_word_type                  want;
   } step_row_type;

   logic clock = 1'b0;
   logic reset;

   rgba_req_if req_ch ();
   rgba_rsp_if rsp_ch ();
   rgba_csr_if csr_ch ();

   range_gated_block_average u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Averager state mirrored by the bench, plus the register values it has written.
   logic signed [SAMPLE_BITS-1:0] anchor_code;
   int                            fill_count;
   longint                        window_total;
   int                            range_cfg;
   int                            wlen_cfg;

   avg_word_type pending_averages [$];
   int           error_count = 0;
   int           cycle_count = 0;
   logic         idle_on = 1'b1;

   // Advance the mirrored window by one accepted sample and return the word it must produce.
   function automatic avg_word_type predict_average(input logic signed [SAMPLE_BITS-1:0] code);
      avg_word_type word;
      longint       distance;
      longint       mean;
      int           span;
      word = '0;
      distance = longint'(anchor_code) - longint'(code);
      if (distance < 0) distance = -distance;
      // Empty window or a sample out of range: reopen around this sample.
      if (fill_count == 0 || distance > range_cfg) begin
         anchor_code  = code;
         window_total = code;
         fill_count   = 1;
         return word;
      end
      window_total += code;
      fill_count++;
      // Clamp the programmed length into 2..MAX_WINDOW.
      span = (wlen_cfg < 2) ? 2 : (wlen_cfg > MAX_WINDOW) ? MAX_WINDOW : wlen_cfg;
      // A length lowered mid-window closes on the first join at or past it.
      if (fill_count >= span) begin
         mean = window_total / span;
         if (mean > AVG_MAX) mean = AVG_MAX;
         if (mean < AVG_MIN) mean = AVG_MIN;
         word.avg_ready = 1'b1;
         word.average   = SAMPLE_BITS'(mean);
         // Restart holding only the kept reference.
         window_total = anchor_code;
         fill_count   = 1;
      end
      return word;
   endfunction

   function automatic step_row_type sample_row(input int value);
      step_row_type row;
      row = '0;
      row.kind = ROW_SAMPLE;
      row.code = SAMPLE_BITS'(value);
      return row;
   endfunction

   function automatic step_row_type fixed_row(input int value, input logic rdy, input int avg);
      step_row_type row;
      row = sample_row(value);
      row.typed = 1'b1;
      row.want.avg_ready = rdy;
      row.want.average   = SAMPLE_BITS'(avg);
      return row;
   endfunction

   function automatic step_row_type write_row(input logic [CSR_IDX_W-1:0] index,
                                              input int value);
      step_row_type row;
      row = '0;
      row.kind  = ROW_WRITE;
      row.index = index;
      row.data  = CSR_DATA_W'(value);
      return row;
   endfunction

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, what);
   endtask

   // Present one sample word, hold it until taken, and queue the result it owes.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] code, input logic typed,
                              input avg_word_type typed_word);
      avg_word_type word;
      int           gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid  <= 1'b1;
      req_ch.sample <= code;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      word = predict_average(code);
      pending_averages.push_back(typed ? typed_word : word);
   endtask

   // Drop the sample valid and wait until every owed result word has come back.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_averages.size() != 0) @(negedge clock);
   endtask

   // Write one register word; mirror it once the block has taken it.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      if (index == REG_RANGE_LIMIT) range_cfg = int'(data[RANGE_W-1:0]);
      else if (index == REG_WINDOW_LEN) wlen_cfg = int'(data[WLEN_W-1:0]);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Draw a sample around the current reference: mostly joining words, some
   // right on the range edge, some just past it, plus raw noise and extremes.
   function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
      int offset;
      int value;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: offset = int'($urandom_range(0, 2 * range_cfg)) - range_cfg;
         6: offset = $urandom_range(0, 1) ? range_cfg : -range_cfg;
         7: offset = $urandom_range(0, 1) ? range_cfg + 1 : -range_cfg - 1;
         8: return SAMPLE_BITS'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0: return SAMPLE_BITS'(AVG_MIN);
               1: return SAMPLE_BITS'(AVG_MAX);
               2: return '0;
               default: return '1;
            endcase
         end
      endcase
      value = int'(anchor_code) + offset;
      if (value > AVG_MAX) value = int'(AVG_MAX);
      if (value < AVG_MIN) value = int'(AVG_MIN);
      return SAMPLE_BITS'(value);
   endfunction

   // Result side: accept words, with random stall bursts while idling is on.
   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0 && idle_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 11);
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each taken result word against the oldest owed word, field by field.
   always @(posedge clock) begin
      avg_word_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_averages.size() == 0) begin
            flag_error($sformatf("result word with nothing owed: avg_ready=%0b average=%0d",
                                 rsp_ch.avg_ready, rsp_ch.average));
         end else begin
            want = pending_averages.pop_front();
            if (rsp_ch.avg_ready !== want.avg_ready)
               flag_error($sformatf("avg_ready: expected %0b, got %0b",
                                    want.avg_ready, rsp_ch.avg_ready));
            if (rsp_ch.average !== want.average)
               flag_error($sformatf("average: expected %0d, got %0d",
                                    want.average, rsp_ch.average));
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("range_gated_block_average test failed");
         $finish;
      end
   end

   initial begin
      step_row_type script [$];
      int           burst;
      int           pick;

      // Drive every input to a known value and hold reset.
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = REG_RANGE_LIMIT;
      csr_ch.data   = '0;

      // Mirror the post-reset state: empty window, default registers.
      anchor_code  = '0;
      fill_count   = 0;
      window_total = 0;
      range_cfg    = int'(RANGE_RESET);
      wlen_cfg     = int'(WLEN_RESET);

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed script. Typed results are the ones that can be read off directly:
      // window openings, pure extremes and saturated means.
      script = '{
         // First word after reset opens the window at the top code.
         fixed_row(32767, 1'b0, 0),
         write_row(REG_WINDOW_LEN, 2),
         fixed_row(32767, 1'b1, 32767),
         // Exactly range_limit away still joins.
         sample_row(31767),
         // Far away: reopen at the bottom code.
         fixed_row(-32768, 1'b0, 0),
         fixed_row(-32768, 1'b1, -32768),
         // Odd negative sum truncates toward zero.
         sample_row(-32767),
         // One code past the range reopens.
         fixed_row(-31767, 1'b0, 0),
         write_row(REG_RANGE_LIMIT, 0),
         fixed_row(-31767, 1'b1, -31767),
         fixed_row(-31766, 1'b0, 0),
         write_row(REG_RANGE_LIMIT, 16'hFFFF),
         // Length 0 acts as 2.
         write_row(REG_WINDOW_LEN, 0),
         sample_row(32767),
         // Length 1 acts as 2.
         write_row(REG_WINDOW_LEN, 1),
         sample_row(-1),
         // Lower the length mid-window; the overfull sum saturates high.
         write_row(REG_WINDOW_LEN, 8),
         write_row(REG_RANGE_LIMIT, 0),
         fixed_row(32767, 1'b0, 0),
         fixed_row(32767, 1'b0, 0),
         fixed_row(32767, 1'b0, 0),
         fixed_row(32767, 1'b0, 0),
         write_row(REG_WINDOW_LEN, 3),
         fixed_row(32767, 1'b1, 32767),
         // Same again on the negative side.
         write_row(REG_WINDOW_LEN, 8),
         fixed_row(-32768, 1'b0, 0),
         fixed_row(-32768, 1'b0, 0),
         fixed_row(-32768, 1'b0, 0),
         write_row(REG_WINDOW_LEN, 2),
         fixed_row(-32768, 1'b1, -32768),
         // Length above the maximum clamps to 256; a write to an unmapped index
         // carrying a length of 2 must not close the next window.
         write_row(REG_WINDOW_LEN, 16'hFFFF),
         write_row(REG_UNMAPPED, 2),
         fixed_row(-32768, 1'b0, 0)
      };

      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            settle();
            write_register(script[i].index, script[i].data);
         end else begin
            send_sample(script[i].code, script[i].typed, script[i].want);
         end
      end

      // Random phases: reprogram while idle, then stream samples.
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         settle();
         idle_on = (phase < RAND_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
         if (phase == LONG_PHASE) begin
            // Fill a maximum-length window: every sample joins at the widest range.
            write_register(REG_RANGE_LIMIT, 16'hFFFF);
            write_register(REG_WINDOW_LEN,
                           CSR_DATA_W'($urandom_range(0, 1) ? MAX_WINDOW
                                                            : $urandom_range(MAX_WINDOW, 511)));
            burst = MAX_WINDOW + 4;
         end else begin
            pick = $urandom_range(0, 3);
            // Skip one of the two registers now and then to keep the old value.
            if (pick != 0) begin
               case ($urandom_range(0, 4))
                  0: write_register(REG_RANGE_LIMIT, '0);
                  1: write_register(REG_RANGE_LIMIT, 16'hFFFF);
                  2, 3: write_register(REG_RANGE_LIMIT, CSR_DATA_W'($urandom_range(1, 2000)));
                  default: write_register(REG_RANGE_LIMIT,
                                          CSR_DATA_W'($urandom_range(0, 65535)));
               endcase
            end
            if (pick != 1) begin
               case ($urandom_range(0, 5))
                  0: write_register(REG_WINDOW_LEN, CSR_DATA_W'($urandom_range(0, 1)));
                  1, 2, 3: write_register(REG_WINDOW_LEN, CSR_DATA_W'($urandom_range(2, 8)));
                  4: write_register(REG_WINDOW_LEN, CSR_DATA_W'($urandom_range(9, 20)));
                  default: write_register(REG_WINDOW_LEN,
                                          CSR_DATA_W'($urandom_range(0, 65535)));
               endcase
            end
            if ($urandom_range(0, 3) == 0)
               write_register(CSR_IDX_W'($urandom_range(REG_WINDOW_LEN + 1, (1 << CSR_IDX_W) - 1)),
                              CSR_DATA_W'($urandom_range(0, 65535)));
            burst = $urandom_range(10, 24);
         end
         repeat (burst) send_sample(draw_sample(), 1'b0, '0);
      end

      // Drain, then watch a little longer for stray result words.
      settle();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0 && pending_averages.size() == 0) begin
         $display("range_gated_block_average test passed");
      end else begin
         $display("range_gated_block_average test failed");
      end
      $finish;
   end

endmodule
